FILE: sv/vsd_pkg.sv
`default_nettype none
package vsd_pkg;

   localparam int unsigned POS_W       = 4;
   localparam logic [3:0]  LAST_POS    = 4'd8;   // ninth byte position
   localparam int unsigned GROUP_BITS  = 7;
   localparam int unsigned TOP_SHIFT   = 56;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      MODE_UNSIGNED_PLAIN = 2'd0,
      MODE_UNSIGNED_BIJ   = 2'd1,
      MODE_SIGNED_PLAIN   = 2'd2,
      MODE_SIGNED_BIJ     = 2'd3
   } mode_type;

   typedef enum logic {
      STATUS_OK        = 1'b0,
      STATUS_TRUNCATED = 1'b1
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_item_type;

   typedef struct packed {
      logic [63:0] value;
      logic [3:0]  byte_count;
      logic        status;
   } rsp_item_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic [63:0] addend;
      logic [3:0]  byte_count;
      logic        done;
      logic        trunc;
      logic        bijective;
      logic        is_signed;
   } op_type;

endpackage
`default_nettype wire

FILE: sv/vsd_front.sv
`default_nettype none
module vsd_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   accept,
   input  vsd_pkg::req_item_type req_item,
   input  vsd_pkg::mode_type     mode,
   output vsd_pkg::op_type       op
);
   import vsd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             ninth;
   logic [5:0]       shift;
   logic [63:0]      low_part;

   assign ninth = (pos_ff >= LAST_POS);
   assign shift = 6'(pos_ff[2:0]) * 6'(GROUP_BITS);

   // low seven bits plus the bijective offset one place above them
   assign low_part = {56'd0,
                      req_item.data_byte[7] & mode[0],
                      req_item.data_byte[6:0]};

   always_comb begin
      op.bijective  = mode[0];
      op.is_signed  = mode[1];
      op.byte_count = pos_ff + 4'd1;
      if (ninth) begin
         op.addend = {req_item.data_byte, TOP_SHIFT'(0)};
         op.done   = 1'b1;
      end else begin
         op.addend = low_part << shift;
         op.done   = ~req_item.data_byte[7];
      end
      op.trunc = ~op.done & req_item.end_of_buffer;
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (op.done || op.trunc) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/vsd_queue.sv
`default_nettype none
module vsd_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              wr_en,
   input  vsd_pkg::op_type  wr_data,
   output logic             full,
   input  wire              rd_en,
   output vsd_pkg::op_type  rd_data,
   output logic             empty
);
   import vsd_pkg::*;

   op_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_wr, do_rd;

   assign full    = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/vsd_back.sv
`default_nettype none
module vsd_back (
   input  wire                   clock,
   input  wire                   reset,
   input  vsd_pkg::op_type       op,
   input  wire                   op_empty,
   output logic                  op_pop,
   input  wire                   pop,
   output logic                  empty,
   output vsd_pkg::rsp_item_type rsp_item
);
   import vsd_pkg::*;

   // accumulator
   logic [63:0]       acc_ff, acc_in;
   logic [63:0]       sum;

   // remap stage
   logic              stg_valid_ff, stg_valid_in;
   logic [63:0]       stg_raw_ff;
   logic [3:0]        stg_count_ff;
   logic              stg_status_ff;
   logic              stg_remap_ff;
   logic              stg_bij_ff;
   logic              stg_ready;
   logic              finish;

   // remap logic
   logic              neg;
   logic [63:0]       squeezed;
   logic [63:0]       remapped;
   rsp_item_type      rsp_new;

   // result queue
   rsp_item_type      outq_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] owr_ptr_ff, owr_ptr_in;
   logic [QUEUE_AW-1:0] ord_ptr_ff, ord_ptr_in;
   logic [QUEUE_AW:0]   ocount_ff, ocount_in;
   logic                out_full, out_push, out_pop;

   assign out_full  = (ocount_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty     = (ocount_ff == '0);
   assign out_push  = stg_valid_ff & ~out_full;
   assign out_pop   = pop & ~empty;
   assign rsp_item  = outq_ff[ord_ptr_ff];

   assign stg_ready = ~stg_valid_ff | ~out_full;
   assign op_pop    = ~op_empty & stg_ready;
   assign sum       = acc_ff + op.addend;
   assign finish    = op.done | op.trunc;

   always_comb begin
      acc_in = acc_ff;
      if (op_pop) begin
         acc_in = finish ? 64'd0 : sum;
      end
      stg_valid_in = stg_valid_ff;
      if (op_pop && finish) begin
         stg_valid_in = 1'b1;
      end else if (out_push) begin
         stg_valid_in = 1'b0;
      end
   end

   // drop sign bit 6, pull bits 63..7 down one place
   assign neg      = stg_raw_ff[6];
   assign squeezed = {1'b0, stg_raw_ff[63:7], stg_raw_ff[5:0]};

   always_comb begin
      remapped = stg_raw_ff;
      if (stg_remap_ff) begin
         if (stg_bij_ff) begin
            remapped = squeezed ^ {64{neg}};
         end else if (neg) begin
            remapped = (64'd0 - squeezed) | {1'b1, 63'd0};
         end else begin
            remapped = squeezed;
         end
      end
      rsp_new.value      = remapped;
      rsp_new.byte_count = stg_count_ff;
      rsp_new.status     = stg_status_ff;
   end

   always_ff @(posedge clock) begin
      if (op_pop && finish) begin
         stg_raw_ff    <= op.done ? sum : 64'd0;
         stg_count_ff  <= op.byte_count;
         stg_status_ff <= op.done ? STATUS_OK : STATUS_TRUNCATED;
         stg_remap_ff  <= op.done & op.is_signed;
         stg_bij_ff    <= op.bijective;
      end
      if (out_push) begin
         outq_ff[owr_ptr_ff] <= rsp_new;
      end
   end

   always_comb begin
      owr_ptr_in = out_push ? owr_ptr_ff + 1'b1 : owr_ptr_ff;
      ord_ptr_in = out_pop ? ord_ptr_ff + 1'b1 : ord_ptr_ff;
      ocount_in  = ocount_ff;
      if (out_push && !out_pop) begin
         ocount_in = ocount_ff + 1'b1;
      end else if (out_pop && !out_push) begin
         ocount_in = ocount_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         stg_valid_ff <= 1'b0;
         owr_ptr_ff   <= '0;
         ord_ptr_ff   <= '0;
         ocount_ff    <= '0;
      end else begin
         acc_ff       <= acc_in;
         stg_valid_ff <= stg_valid_in;
         owr_ptr_ff   <= owr_ptr_in;
         ord_ptr_ff   <= ord_ptr_in;
         ocount_ff    <= ocount_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/varint_stream_decoder.sv
// a result item becomes visible once its final byte has passed the op queue, the remap stage and the result queue
// throughput: one byte item per cycle while the result queue is being drained
// the accumulator add in the back end takes one byte per cycle while the remap stage is free
// reset: synchronous, active high; clears mode, position, accumulator and both queues
// both queues hold 4 items, so each side can stall for a while on its own
`default_nettype none
module varint_stream_decoder (
   input  wire                   clock,
   input  wire                   reset,
   // input item channel
   input  wire                   push,
   output logic                  full,
   input  vsd_pkg::req_item_type req_item,
   // result item channel
   input  wire                   pop,
   output logic                  empty,
   output vsd_pkg::rsp_item_type rsp_item,
   // mode register write
   input  wire                   valid,
   output logic                  ready,
   input  wire [1:0]             csr_wdata
);
   import vsd_pkg::*;

   mode_type mode_ff, mode_in;
   logic     accept;
   op_type   front_op;
   op_type   back_op;
   logic     op_empty;
   logic     op_pop;

   // mode register, always writable
   assign ready   = 1'b1;
   assign mode_in = (valid && ready) ? mode_type'(csr_wdata) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UNSIGNED_PLAIN;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign accept = push & ~full;

   // front: tracks byte position, builds the shifted addend and end flags
   vsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .mode     (mode_ff),
      .op       (front_op)
   );

   // decoupling queue between front and back
   vsd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (front_op),
      .full    (full),
      .rd_en   (op_pop),
      .rd_data (back_op),
      .empty   (op_empty)
   );

   // back: accumulate, remap signed values, queue up result items
   vsd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op       (back_op),
      .op_empty (op_empty),
      .op_pop   (op_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_item (rsp_item)
   );

`ifndef SYNTH
   // a truncated item never carries a value
   a_trunc_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.status == STATUS_TRUNCATED) |-> rsp_item.value == 64'd0)
      else $error("truncated item with non-zero value");

   // byte count stays within one to nine
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.byte_count != 4'd0 && rsp_item.byte_count <= 4'd9))
      else $error("byte count out of range");

   // a truncation can only happen before the ninth byte
   a_trunc_short: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.status == STATUS_TRUNCATED) |-> rsp_item.byte_count <= 4'd8)
      else $error("truncation on ninth byte");

   // nothing waiting straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_varint_stream_decoder.sv
`timescale 1ns / 1ps

module tb_varint_stream_decoder;
   import vsd_pkg::*;

   localparam int TOTAL_ITEMS  = 1450;  // byte items offered over the whole run
   localparam int PHASE_ITEMS  = 110;   // bytes per mode setting, roughly
   localparam int QUIET_ITEMS  = 160;   // final stretch driven without idling
   localparam int LONG_HOLD    = 200;   // cycles the receiver holds off when asked
   localparam int SETTLE_CYCLES = 8;    // idle margin after the last owed result
   localparam int LIMIT_NS     = 8_000_000;

   // ---------------------------------------------------------------------
   // decode tracker: own copy of mode, accumulator and position, and the
   // queue of decoded values still owed by the block
   // ---------------------------------------------------------------------
   class varint_tracker;
      mode_type     mode;
      logic [63:0]  acc;
      logic [3:0]   seen;
      rsp_item_type owed_decodes[$];
      int           errors;
      int           n_bytes;
      int           n_values;
      int           n_truncs;
      int           per_mode[4];

      function new();
         mode     = MODE_UNSIGNED_PLAIN;
         acc      = '0;
         seen     = '0;
         errors   = 0;
         n_bytes  = 0;
         n_values = 0;
         n_truncs = 0;
         foreach (per_mode[i]) per_mode[i] = 0;
      endfunction

      function void set_mode(mode_type m);
         mode = m;
      endfunction

      function int owed();
         return owed_decodes.size();
      endfunction

      // sign sits in bit 6; bits 63..7 slide down one place over it
      function logic [63:0] signed_remap(logic [63:0] u, bit bij);
         logic [63:0] v;
         v = {1'b0, u[63:7], u[5:0]};
         if (bij)
            return v ^ {64{u[6]}};
         if (u[6])
            v = ~(v - 64'd1) | {1'b1, 63'd0};
         return v;
      endfunction

      // one accepted byte: advance the decode and queue any result it ends
      function void note_byte(req_item_type it);
         logic [3:0]   pos;
         int unsigned  shift;
         bit           done;
         bit           bij;
         rsp_item_type r;
         n_bytes++;
         bij  = (mode == MODE_UNSIGNED_BIJ) || (mode == MODE_SIGNED_BIJ);
         pos  = seen;
         done = 0;
         if (pos >= LAST_POS) begin
            // ninth byte: all eight bits at the top, always final
            pos  = LAST_POS;
            acc  = acc + {it.data_byte, 56'd0};
            done = 1;
         end else begin
            shift = GROUP_BITS * pos;
            acc   = acc + (64'(it.data_byte[6:0]) << shift);
            if (!it.data_byte[7])
               done = 1;
            else if (bij)
               acc = acc + (64'd1 << (shift + GROUP_BITS));
         end
         if (done) begin
            r.value = acc;
            if ((mode == MODE_SIGNED_PLAIN) || (mode == MODE_SIGNED_BIJ))
               r.value = signed_remap(acc, bij);
            r.byte_count = pos + 4'd1;
            r.status     = STATUS_OK;
            owed_decodes.push_back(r);
            per_mode[mode]++;
            acc  = '0;
            seen = '0;
         end else if (it.end_of_buffer) begin
            r.value      = '0;
            r.byte_count = pos + 4'd1;
            r.status     = STATUS_TRUNCATED;
            owed_decodes.push_back(r);
            acc  = '0;
            seen = '0;
         end else begin
            seen = pos + 4'd1;
         end
      endfunction

      function void check_decode(rsp_item_type got);
         rsp_item_type want;
         if (owed_decodes.size() == 0) begin
            $error("result item with nothing owed: value %h count %0d status %0d",
                   got.value, got.byte_count, got.status);
            errors++;
            return;
         end
         want = owed_decodes.pop_front();
         if (want.status == STATUS_OK) n_values++;
         else n_truncs++;
         if (got.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, got.value);
            errors++;
         end
         if (got.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
      endfunction

      function void close_out();
         if (owed_decodes.size() != 0) begin
            $error("%0d result items never arrived", owed_decodes.size());
            errors++;
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // clock, dut
   // ---------------------------------------------------------------------
   logic         clock;
   logic         reset;
   logic         push;
   logic         full;
   req_item_type req_item;
   logic         pop;
   logic         empty;
   rsp_item_type rsp_item;
   logic         valid;
   logic         ready;
   logic [1:0]   csr_wdata;

   varint_tracker decoder_model;
   bit            idle_on;     // random idling on both sides
   bit            hold_req;    // ask the receiver for one long hold-off
   int            bytes_sent;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   varint_stream_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .pop       (pop),
      .empty     (empty),
      .rsp_item  (rsp_item),
      .valid     (valid),
      .ready     (ready),
      .csr_wdata (csr_wdata)
   );

   // overall time limit
   initial begin
      #(LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------
   function automatic req_item_type byte_item(logic [7:0] b, logic eob);
      req_item_type it;
      it.data_byte     = b;
      it.end_of_buffer = eob;
      return it;
   endfunction

   // called at a falling edge, returns at a falling edge with push still high
   task automatic send_byte(req_item_type it);
      if (idle_on && ($urandom_range(0, 7) == 0)) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      push     <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      decoder_model.note_byte(it);
      bytes_sent++;
      @(negedge clock);
   endtask

   // stop offering, wait for every owed result, then let the pipeline settle
   task automatic settle();
      push <= 1'b0;
      while (decoder_model.owed() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(mode_type m);
      valid     <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      while (!ready) @(posedge clock);
      decoder_model.set_mode(m);
      @(negedge clock);
      valid <= 1'b0;
   endtask

   // one random value: mostly well formed, some truncated, some noise
   task automatic send_value();
      int         kind;
      int         len;
      logic [7:0] b;
      logic       eob;
      kind = $urandom_range(0, 9);
      if (kind >= 8) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++)
            send_byte(byte_item($urandom_range(0, 255), $urandom_range(0, 1)));
      end else if (kind == 7) begin
         // continuation bytes cut short by the end of the buffer
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            b    = $urandom_range(0, 255);
            b[7] = 1'b1;
            send_byte(byte_item(b, i == len - 1));
         end
      end else begin
         len = $urandom_range(1, 9);
         for (int i = 0; i < len; i++) begin
            b = $urandom_range(0, 255);
            if (i < len - 1) b[7] = 1'b1;
            else if (len < 9) b[7] = 1'b0;
            eob = (i == len - 1) && ($urandom_range(0, 3) == 0);
            send_byte(byte_item(b, eob));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // receiver side: pops with random bursts of idling and, on request,
   // one long hold-off so the queues fill and the input stalls
   // ---------------------------------------------------------------------
   initial begin
      pop = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_req) begin
            pop <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_req = 1'b0;
         end else if (idle_on && ($urandom_range(0, 9) == 0)) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         if (!empty) decoder_model.check_decode(rsp_item);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      mode_type    phase_mode;
      int          phase;
      int          phase_start;
      mode_type    opening[4];
      decoder_model = new();
      opening    = '{MODE_SIGNED_BIJ, MODE_UNSIGNED_PLAIN, MODE_SIGNED_PLAIN,
                     MODE_UNSIGNED_BIJ};
      idle_on    = 1'b0;
      hold_req   = 1'b0;
      bytes_sent = 0;
      reset      = 1'b1;
      push       = 1'b0;
      req_item   = '0;
      valid      = 1'b0;
      csr_wdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: plain unsigned first
      write_mode(MODE_UNSIGNED_PLAIN);
      send_byte(byte_item(8'h00, 1'b0));
      // completion and end of buffer on the same byte
      send_byte(byte_item(8'h7f, 1'b1));
      // longest value, ninth byte carries all eight bits
      repeat (9) send_byte(byte_item(8'hff, 1'b0));
      // truncated after two bytes, and on the very first byte
      send_byte(byte_item(8'h80, 1'b0));
      send_byte(byte_item(8'h80, 1'b1));
      send_byte(byte_item(8'hff, 1'b1));
      settle();

      // signed bijective: sign bit alone, then the widest wrap
      write_mode(MODE_SIGNED_BIJ);
      send_byte(byte_item(8'h40, 1'b0));
      repeat (9) send_byte(byte_item(8'hff, 1'b0));
      settle();

      // signed plain: negative zero magnitude
      write_mode(MODE_SIGNED_PLAIN);
      send_byte(byte_item(8'h40, 1'b1));
      settle();

      // random phases, one mode setting each
      idle_on = 1'b1;
      phase   = 0;
      while (bytes_sent < TOTAL_ITEMS) begin
         phase_mode = (phase < 4) ? opening[phase] : mode_type'($urandom_range(0, 3));
         write_mode(phase_mode);
         if ((phase == 1) || (phase == 4)) hold_req = 1'b1;
         if (bytes_sent > TOTAL_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
         phase_start = bytes_sent;
         while ((bytes_sent - phase_start < PHASE_ITEMS) && (bytes_sent < TOTAL_ITEMS))
            send_value();
         // sometimes leave a value half done across the mode change
         if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 7))
               send_byte(byte_item(8'h80 | 8'($urandom_range(0, 127)), 1'b0));
         // the sender pauses here until every owed result has come
         settle();
         phase++;
      end

      repeat (20) @(negedge clock);
      decoder_model.close_out();
      $display("run covered %0d bytes over %0d mode settings: %0d values, %0d truncations",
               decoder_model.n_bytes, phase + 3, decoder_model.n_values,
               decoder_model.n_truncs);
      $display("values per mode: plain %0d, bijective %0d, signed plain %0d, signed bij %0d",
               decoder_model.per_mode[0], decoder_model.per_mode[1],
               decoder_model.per_mode[2], decoder_model.per_mode[3]);
      if (decoder_model.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: varint_stream_decoder.f
sv/vsd_pkg.sv
sv/vsd_front.sv
sv/vsd_queue.sv
sv/vsd_back.sv
sv/varint_stream_decoder.sv
tb/tb_varint_stream_decoder.sv
